// File: hdl/ksf_pkg.sv
// Package for the spanning forest block: shared result record type.
// No dependencies.
package ksf_pkg;

  typedef struct packed {
    logic [3:0]  va;
    logic [3:0]  vb;
    logic [31:0] w;
    logic        ev;
    logic        ovf;
    logic        lst;
  } result_t;

endpackage

// File: hdl/ksf_store.sv
// Edge store: one synchronous memory of {a, b, weight} entries.
// Depends on nothing; used by kruskal_spanning_forest.
module ksf_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [39:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [39:0]   rdata
);
  logic [39:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/kruskal_spanning_forest.sv
// Top level of the spanning forest block: load, sort and scan sequencer.
// Depends on ksf_pkg and ksf_store.
//
//  channel | beat fields                                          | handshake
//  input   | vertex_a vertex_b weight last_edge                   | in_valid/in_stall
//  output  | out_vertex_a out_vertex_b out_weight edge_valid ...  | out_valid/out_stall
//
// Edges load at one beat per cycle while in_stall is low. On the last edge
// the store is sorted by selection over the memory: each pass reads all N
// entries through the single read port. Each accepted edge is held back
// until the next one is found, so that the final one can carry last_result.
// Reset is synchronous; no input is taken while a set is being processed.
// Results wait in an output register while out_stall is high.
module kruskal_spanning_forest #(
  parameter int MAX_EDGES    = 64,
  parameter int MAX_VERTICES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  vertex_a,
  input  logic [3:0]  vertex_b,
  input  logic [31:0] weight,
  input  logic        last_edge,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_vertex_a,
  output logic [3:0]  out_vertex_b,
  output logic [31:0] out_weight,
  output logic        edge_valid,
  output logic        overflowed,
  output logic        last_result
);
  import ksf_pkg::*;

  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_EDGE = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]    state;
  logic [CW-1:0] count;
  logic          ovf;
  logic [VW-1:0] label [MAX_VERTICES];
  // Selection state: the previous chosen key (weight, index); the pass looks
  // for the smallest key strictly above it.
  logic [31:0]   prev_w;
  logic [AW-1:0] prev_i;
  logic          have_prev;
  logic [31:0]   best_w;
  logic [AW-1:0] best_i;
  logic          have_best;
  logic [CW-1:0] pass;
  logic [CW-1:0] ridx;
  logic          rvalid;
  logic [AW-1:0] rtag;
  logic          any_out;
  logic          obuf_full;
  logic          obuf_load;
  result_t       obuf;
  result_t       pend;

  logic          we;
  logic [AW-1:0] raddr;
  logic [39:0]   rdata;

  ksf_store #(.DEPTH(MAX_EDGES), .AW(AW)) u_store (
    .clk(clk), .we(we), .waddr(count[AW-1:0]),
    .wdata({vertex_a, vertex_b, weight}), .raddr(raddr), .rdata(rdata)
  );

  assign in_stall = (state != S_LOAD);
  assign we       = in_valid && !in_stall && (count < CW'(MAX_EDGES));
  // The chosen entry stays on the read address while its result waits.
  assign raddr    = (state == S_EDGE || state == S_OUT) ? best_i : ridx[AW-1:0];

  // Candidate compare against the previous key and the running best.
  logic [31:0] rw;
  logic        above_prev, below_best;
  assign rw         = rdata[31:0];
  assign above_prev = !have_prev || (rw > prev_w) || (rw == prev_w && rtag > prev_i);
  assign below_best = !have_best || (rw < best_w);

  logic [3:0] ea, eb;
  logic       in_range, differ;
  logic [VW-1:0] la, lb;
  assign ea = rdata[39:36];
  assign eb = rdata[35:32];
  assign in_range = (32'(ea) < MAX_VERTICES) && (32'(eb) < MAX_VERTICES);
  assign la = label[VW'(ea)];
  assign lb = label[VW'(eb)];
  assign differ = in_range && (la != lb);

  assign out_valid    = obuf_full;
  assign out_vertex_a = obuf.va;
  assign out_vertex_b = obuf.vb;
  assign out_weight   = obuf.w;
  assign edge_valid   = obuf.ev;
  assign overflowed   = obuf.ovf;
  assign last_result  = obuf.lst;

  logic emit_ok;
  assign emit_ok = !obuf_full || !out_stall;

  // The output register is loaded when a held edge is released or the set ends.
  assign obuf_load = emit_ok && ((state == S_OUT && differ && any_out) || state == S_FIN);

  // Output register occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      obuf_full <= 1'b0;
    end else if (obuf_load) begin
      obuf_full <= 1'b1;
    end else if (!out_stall) begin
      obuf_full <= 1'b0;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      ovf       <= 1'b0;
      for (int v = 0; v < MAX_VERTICES; v++) label[v] <= VW'(v);
    end else begin
      case (state)
        S_LOAD: begin
          if (in_valid) begin
            if (count < CW'(MAX_EDGES)) count <= count + 1'b1;
            else ovf <= 1'b1;
            if (last_edge) begin
              state     <= S_RD;
              have_prev <= 1'b0;
              pass      <= '0;
              any_out   <= 1'b0;
              ridx      <= '0;
              rvalid    <= 1'b0;
              have_best <= 1'b0;
            end
          end
        end
        S_RD: begin
          // Start a sweep of all entries, read one per cycle in S_SCAN, or finish.
          if (pass == count) begin
            state <= S_FIN;
          end else begin
            ridx  <= '0;
            rvalid <= 1'b0;
            have_best <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rvalid && above_prev && below_best) begin
            best_w <= rw; best_i <= rtag; have_best <= 1'b1;
          end
          if (ridx < count) begin
            rtag   <= ridx[AW-1:0];
            rvalid <= 1'b1;
            ridx   <= ridx + 1'b1;
          end else if (rvalid) begin
            rvalid <= 1'b0;
          end else begin
            state <= S_EDGE;
          end
        end
        S_EDGE: begin
          // best_i is on the read address; data arrives next cycle.
          state <= S_OUT;
        end
        S_OUT: begin
          if (emit_ok) begin
            if (differ) begin
              for (int v = 0; v < MAX_VERTICES; v++)
                if (label[v] == lb) label[v] <= la;
              // Release the previously held edge and hold this one.
              if (any_out) obuf <= pend;
              pend <= '{va: ea, vb: eb, w: rw, ev: 1'b1, ovf: ovf, lst: 1'b0};
              any_out <= 1'b1;
            end
            prev_w <= best_w; prev_i <= best_i; have_prev <= 1'b1;
            pass   <= pass + 1'b1;
            state  <= S_RD;
          end
        end
        S_FIN: begin
          if (emit_ok) begin
            if (any_out) begin
              obuf <= '{va: pend.va, vb: pend.vb, w: pend.w, ev: 1'b1, ovf: ovf,
                        lst: 1'b1};
            end else begin
              obuf <= '{va: '0, vb: '0, w: '0, ev: 1'b0, ovf: ovf, lst: 1'b1};
            end
            count <= '0;
            ovf   <= 1'b0;
            for (int v = 0; v < MAX_VERTICES; v++) label[v] <= VW'(v);
            state <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule

// File: hdl/ksf_checker.sv
// Port checker for the spanning forest block, bound to the top level.
// Depends on kruskal_spanning_forest ports only.
module ksf_checker (
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic edge_valid,
  input logic last_result,
  input logic [31:0] out_weight
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_weight)) else $error("hold");
  a_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && !edge_valid |-> last_result && out_weight == 32'd0) else $error("marker");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_result |-> in_stall) else $error("busy");
endmodule

bind kruskal_spanning_forest ksf_checker u_chk (
  .clk(clk), .rst(rst), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .edge_valid(edge_valid), .last_result(last_result),
  .out_weight(out_weight)
);
